// ===== src/ccm_pkg.sv =====
// Package for the cube coordinate mapping block.
// Holds the beat types, axis codes and fixed level constants.
// No dependencies.
package ccm_pkg;

	// Widths fixed by the beat format.
	localparam int RANK_W      = 16;
	localparam int CUBE_W      = 4;
	localparam int CFG_W       = 32;
	localparam int CORNER_W    = 21;
	localparam int AXES        = 3;
	localparam int CUBE_LEVELS = 4;

	// Log2 of the starting box on every axis (a box of 4).
	localparam int START_LOG = 2;

	// Axis codes as stored in the level list.
	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	// Fixed axis order walked by the cube number, high bit first.
	localparam axis_t CUBE_AXES [CUBE_LEVELS] = '{AXIS_X, AXIS_Y, AXIS_Z, AXIS_Z};

	// Input beat.
	typedef struct packed {
		logic [RANK_W-1:0] macroblock_rank;
		logic [CUBE_W-1:0] cube_index;
	} query_t;

	// Result beat.
	typedef struct packed {
		logic [CORNER_W-1:0] corner_x;
		logic [CORNER_W-1:0] corner_y;
		logic [CORNER_W-1:0] corner_z;
		logic                step_neg_x;
		logic                step_neg_y;
		logic                step_neg_z;
	} result_t;

	// Decode a two-bit level entry; the unused code is taken as z.
	function automatic axis_t decode_axis(input logic [1:0] code);
		axis_t ax;
		case (code)
			2'd0: ax = AXIS_X;
			2'd1: ax = AXIS_Y;
			default: ax = AXIS_Z;
		endcase
		return ax;
	endfunction

endpackage

// ===== src/cube_coordinate_mapping.sv =====
// Top level of the cube coordinate mapping block.
// Maps a cube number and macroblock rank to corner coordinates and step signs.
// Depends on ccm_pkg.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------------
//  query   | query_valid / query_stall | query_t: macroblock_rank, cube_index
//  result  | result_valid/result_stall | result_t: corners and step signs
//  cfg     | cfg_valid / cfg_ready     | cfg_data: level axis list
//
// One query beat is taken every cycle while query_stall is low; each beat
// passes through the input register and then the result register.
// Each corner is formed by one subtraction of two masks of box bits.
// Reset clears the valid flags and the level axis list to zero.
// A stalled result holds the result register; the input register still
// takes a beat whenever it is empty or moving on.
module cube_coordinate_mapping
	import ccm_pkg::*;
#(
	parameter int RANK_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             query_valid,
	output logic             query_stall,
	input  query_t           query,
	output logic             result_valid,
	input  logic             result_stall,
	output result_t          result,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	logic             valid_s1;
	query_t           query_s1;
	logic             valid_s2;
	result_t          result_s2;
	logic [CFG_W-1:0] level_axis_q;
	logic             adv_s2;

	logic [RANK_BITS-1:0] on_lvl  [AXES];
	logic [RANK_BITS-1:0] hit_lvl [AXES];
	logic [CORNER_W-1:0]  pos_sum [AXES];
	logic [CORNER_W-1:0]  neg_sum [AXES];
	logic [AXES-1:0]      neg_c;
	logic [CORNER_W-1:0]  corner_c [AXES];

	// The register can always be written.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_axis_q <= '0;
		end else if (cfg_valid) begin
			level_axis_q <= cfg_data;
		end
	end

	// Pipeline flow control.
	assign adv_s2      = !valid_s2 || !result_stall;
	assign query_stall = valid_s1 && !adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!query_stall) begin
			valid_s1 <= query_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (query_valid && !query_stall) begin
			query_s1 <= query;
		end
	end

	// Per-level axis match and set bits of the rank.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			for (int b = 0; b < RANK_BITS; b++) begin
				on_lvl[a][b]  = (decode_axis(level_axis_q[2*b +: 2]) == axis_t'(2'(a)));
				hit_lvl[a][b] = on_lvl[a][b] && query_s1.macroblock_rank[b];
			end
		end
	end

	// Each reflection is corner = box - corner, so the final corner is an
	// alternating sum of distinct box powers. A set level adds its box when
	// an even number of set levels on the same axis follow it, and
	// subtracts it otherwise.
	always_comb begin
		int  cube_cnt;
		int  lvl_cnt;
		int  rank_cnt;
		logic par;
		logic later;
		logic bit_j;
		for (int a = 0; a < AXES; a++) begin
			pos_sum[a] = '0;
			neg_sum[a] = '0;
			cube_cnt   = 0;
			for (int j = 0; j < CUBE_LEVELS; j++) begin
				if (CUBE_AXES[j] == axis_t'(2'(a))) begin
					cube_cnt = cube_cnt + 1;
				end
			end

			// Rank levels, whose boxes lie above all cube-level boxes.
			for (int b = 0; b < RANK_BITS; b++) begin
				rank_cnt = 0;
				for (int k = 0; k <= b; k++) begin
					rank_cnt = rank_cnt + int'(on_lvl[a][k]);
				end
				later = ^(hit_lvl[a] >> (b + 1));
				if (hit_lvl[a][b]) begin
					if (!later) begin
						pos_sum[a] = pos_sum[a] |
							(CORNER_W'(1) << (START_LOG + cube_cnt + rank_cnt));
					end else begin
						neg_sum[a] = neg_sum[a] |
							(CORNER_W'(1) << (START_LOG + cube_cnt + rank_cnt));
					end
				end
			end

			// Cube levels, walked from the last one back to the first.
			par = ^hit_lvl[a];
			for (int j = CUBE_LEVELS - 1; j >= 0; j--) begin
				lvl_cnt = 0;
				for (int k = 0; k <= j; k++) begin
					if (CUBE_AXES[k] == axis_t'(2'(a))) begin
						lvl_cnt = lvl_cnt + 1;
					end
				end
				bit_j = query_s1.cube_index[CUBE_LEVELS-1-j] &&
					(CUBE_AXES[j] == axis_t'(2'(a)));
				if (bit_j) begin
					if (!par) begin
						pos_sum[a] = pos_sum[a] | (CORNER_W'(1) << (START_LOG + lvl_cnt));
					end else begin
						neg_sum[a] = neg_sum[a] | (CORNER_W'(1) << (START_LOG + lvl_cnt));
					end
				end
				par = par ^ bit_j;
			end
			neg_c[a] = par;
		end
	end

	// One subtraction per axis gives the corner.
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			corner_c[a] = pos_sum[a] - neg_sum[a];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2.corner_x   <= corner_c[0];
			result_s2.corner_y   <= corner_c[1];
			result_s2.corner_z   <= corner_c[2];
			result_s2.step_neg_x <= neg_c[0];
			result_s2.step_neg_y <= neg_c[1];
			result_s2.step_neg_z <= neg_c[2];
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// An accepted query beat lands in the input register.
	a_query_lands: assert property (@(posedge clk) disable iff (!arst_n)
		query_valid && !query_stall |=> valid_s1)
		else $error("accepted query beat did not reach the input register");

	// A beat leaving the input register lands in the result register.
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("beat lost between input and result registers");

	// An empty result register never holds back the input side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> !query_stall)
		else $error("query stalled while the result register is empty");

	// With no bits set, every corner is zero and every step is positive.
	a_zero_query: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 && (query_s1.cube_index == '0) &&
		(query_s1.macroblock_rank[RANK_BITS-1:0] == '0)
		|=> (result.corner_x == '0) && (result.corner_y == '0) &&
		(result.corner_z == '0) && !result.step_neg_x &&
		!result.step_neg_y && !result.step_neg_z)
		else $error("all-zero query gave a nonzero placement");

endmodule
